// ===== sv/assert_macros.svh =====
// Assertion shorthands used by the checker file pwl_chk.sv.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in the same cycle.
`define PWL_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PWL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pwl_pkg.sv =====
`default_nettype none

package pwl_pkg;

    // Field and register widths.
    localparam int DIST_W   = 32;
    localparam int DELAY_W  = 21;
    localparam int CFG_W    = 16;
    localparam int USED_W   = 5;
    localparam int TSEL_W   = 2;
    localparam int EIDX_W   = 4;
    localparam int CIDX_W   = 2;

    // Stream payload layout.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 24;
    localparam int TSEL_LSB    = 0;
    localparam int EIDX_LSB    = TSEL_LSB + TSEL_W;
    localparam int EDIST_LSB   = EIDX_LSB + EIDX_W;
    localparam int GOAL_LSB    = EDIST_LSB + DIST_W;

    // Default sizes of the table store.
    localparam int TABLES_DEF  = 4;
    localparam int ENTRIES_DEF = 16;

    // Register indexes on the configuration port.
    localparam logic [CIDX_W-1:0] REG_ENTRIES_USED = 2'd0;
    localparam logic [CIDX_W-1:0] REG_DELAY_BASE   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_DELAY_STEP   = 2'd2;

    // Register reset values.
    localparam logic [USED_W-1:0] ENTRIES_USED_RST = 5'd14;
    localparam logic [CFG_W-1:0]  DELAY_BASE_RST   = 16'd0;
    localparam logic [CFG_W-1:0]  DELAY_STEP_RST   = 16'd0;

    // Interpolation arithmetic. The slope is in hundredths, so it never exceeds
    // PCT_SCALE and fits in QUO_W bits; the divider runs one quotient bit a step.
    localparam int PCT_SCALE = 100;
    localparam int QUO_W     = 7;
    localparam int KW        = 3;
    localparam int NUM_W     = DIST_W + QUO_W;
    localparam int PROD_W    = CFG_W + QUO_W;
    localparam logic [KW-1:0] K_INIT = KW'(QUO_W - 1);

    // Division by PCT_SCALE as a multiply by a rounded-up reciprocal; exact for
    // every product below 2**PROD_W.
    localparam int RECIP_SH = 30;
    localparam int RECIP_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((2**RECIP_SH + PCT_SCALE - 1) / PCT_SCALE);
    localparam int RP_W     = PROD_W + RECIP_W;
    localparam int SCALED_W = RP_W - RECIP_SH;

    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    // Datapath operations.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP   = 4'd0;
    localparam logic [OP_W-1:0] OP_SCAN  = 4'd1;
    localparam logic [OP_W-1:0] OP_DIFF  = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
    localparam logic [OP_W-1:0] OP_PROD  = 4'd5;
    localparam logic [OP_W-1:0] OP_RECIP = 4'd6;
    localparam logic [OP_W-1:0] OP_SUM   = 4'd7;
    localparam logic [OP_W-1:0] OP_OOR   = 4'd8;

    // Jump conditions.
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_NEXT    = 3'd0;
    localparam logic [COND_W-1:0] C_BAD     = 3'd1;
    localparam logic [COND_W-1:0] C_MORE    = 3'd2;
    localparam logic [COND_W-1:0] C_MISS    = 3'd3;
    localparam logic [COND_W-1:0] C_DIVMORE = 3'd4;

    // Program steps.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_CHECK = 4'd0;
    localparam logic [STEP_W-1:0] S_FETCH = 4'd1;
    localparam logic [STEP_W-1:0] S_SCAN  = 4'd2;
    localparam logic [STEP_W-1:0] S_TEST  = 4'd3;
    localparam logic [STEP_W-1:0] S_DIFF  = 4'd4;
    localparam logic [STEP_W-1:0] S_SCALE = 4'd5;
    localparam logic [STEP_W-1:0] S_DIV   = 4'd6;
    localparam logic [STEP_W-1:0] S_PROD  = 4'd7;
    localparam logic [STEP_W-1:0] S_RECIP = 4'd8;
    localparam logic [STEP_W-1:0] S_SUM   = 4'd9;
    localparam logic [STEP_W-1:0] S_OOR   = 4'd10;

    // One control word of the program.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ctl_t;

    // Status flags that the datapath returns for jump decisions.
    typedef struct packed {
        logic bad;
        logic more;
        logic miss;
        logic div_more;
    } stat_t;

    // Program store of the query sequencer.
    function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
        ctl_t w;
        w = '{op: OP_NOP, cond: C_NEXT, target: S_CHECK, last: 1'b0};
        unique case (step)
            S_CHECK: begin w.cond = C_BAD; w.target = S_OOR; end
            S_FETCH: begin end
            S_SCAN:  begin w.op = OP_SCAN; w.cond = C_MORE; w.target = S_FETCH; end
            S_TEST:  begin w.cond = C_MISS; w.target = S_OOR; end
            S_DIFF:  w.op = OP_DIFF;
            S_SCALE: w.op = OP_MUL;
            S_DIV:   begin w.op = OP_DIV; w.cond = C_DIVMORE; w.target = S_DIV; end
            S_PROD:  w.op = OP_PROD;
            S_RECIP: w.op = OP_RECIP;
            S_SUM:   begin w.op = OP_SUM; w.last = 1'b1; end
            S_OOR:   begin w.op = OP_OOR; w.last = 1'b1; end
            default: begin w.op = OP_OOR; w.last = 1'b1; end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/pwl_ram.sv =====
`default_nettype none

module pwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/pwl_seq.sv =====
`default_nettype none

module pwl_seq import pwl_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire stat_t stat,
    input  wire logic  out_free,
    output ctl_t       ctl,
    output logic       fire,
    output logic       done,
    output logic       busy
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] upc_reg;
    logic [STEP_W-1:0] upc_next;
    logic              jump;

    // Current control word from the program store.
    assign ctl  = ucode(upc_reg);
    assign busy = busy_reg;

    // The final step waits until the output register can take the result.
    assign fire = busy_reg && (!ctl.last || out_free);
    assign done = fire && ctl.last;

    // Jump condition decode.
    always_comb
    begin
        unique case (ctl.cond)
            C_NEXT:    jump = 1'b0;
            C_BAD:     jump = stat.bad;
            C_MORE:    jump = stat.more;
            C_MISS:    jump = stat.miss;
            C_DIVMORE: jump = stat.div_more;
            default:   jump = 1'b0;
        endcase
    end

    // Step counter update.
    always_comb
    begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            upc_next  = S_CHECK;
        end
        else if (fire)
        begin
            if (ctl.last)
            begin
                busy_next = 1'b0;
            end
            else if (jump)
            begin
                upc_next = ctl.target;
            end
            else
            begin
                upc_next = upc_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            upc_reg  <= S_CHECK;
        end
        else
        begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/pwl_dpath.sv =====
`default_nettype none

module pwl_dpath import pwl_pkg::*; #(
    parameter int TABLES  = TABLES_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [TSEL_W-1:0]                   table_select,
    input  wire logic [DIST_W-1:0]                   goal_distance,
    input  wire logic [USED_W-1:0]                   entries_used,
    input  wire logic [CFG_W-1:0]                    delay_base,
    input  wire logic [CFG_W-1:0]                    delay_step,
    input  wire ctl_t                                ctl,
    input  wire logic                                fire,
    input  wire logic [DIST_W-1:0]                   rd_data,
    output logic      [$clog2(TABLES*ENTRIES)-1:0]   rd_addr,
    output stat_t                                    stat,
    output logic      [DELAY_W-1:0]                  delay,
    output logic                                     out_of_range
);

    localparam int AW     = $clog2(TABLES * ENTRIES);
    localparam int IW     = $clog2(ENTRIES);
    localparam int UW     = $clog2(ENTRIES + 1);
    localparam int CW     = (UW > USED_W) ? UW : USED_W;
    localparam int ACC_W  = IW + CFG_W + 1;
    localparam int SUM_W  = (ACC_W + 1 > DELAY_W + 1) ? ACC_W + 1 : DELAY_W + 1;

    // Control state.
    logic [IW-1:0]       i_reg;
    logic                bad_reg;
    logic                miss_reg;
    logic [KW-1:0]       k_reg;

    // Operand and result registers.
    logic [DIST_W-1:0]   goal_reg;
    logic [AW-1:0]       base_reg;
    logic [DIST_W-1:0]   lower_reg;
    logic [DIST_W-1:0]   upper_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DIST_W-1:0]   den_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [SCALED_W-1:0] scaled_reg;

    logic [CW-1:0]       used_ext;
    logic [UW-1:0]       used;
    logic                tab_ok;
    logic                above;
    logic [NUM_W-1:0]    num_mul;
    logic [NUM_W-1:0]    trial;
    logic [PROD_W-1:0]   prod_next;
    logic [IW-1:0]       im1;
    logic [ACC_W-1:0]    acc_next;
    logic [RP_W-1:0]     rprod;
    logic [SUM_W-1:0]    sum;

    // Entries in use, limited to the table depth.
    assign used_ext = (CW'(entries_used) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(entries_used);
    assign used     = UW'(used_ext);
    assign tab_ok   = 32'(table_select) < 32'(TABLES);

    // Scan compare against the entry read in the previous step.
    assign rd_addr = base_reg + AW'(i_reg);
    assign above   = goal_reg > rd_data;

    assign stat.bad      = bad_reg;
    assign stat.more     = above && ((UW'(i_reg) + UW'(1)) < used);
    assign stat.miss     = miss_reg;
    assign stat.div_more = k_reg != '0;

    // Arithmetic units.
    assign num_mul   = NUM_W'(num_reg[DIST_W-1:0]) * NUM_W'(PCT_SCALE);
    assign trial     = NUM_W'(den_reg) << k_reg;
    assign prod_next = PROD_W'(delay_step) * PROD_W'(quo_reg);
    assign im1       = i_reg - IW'(1);
    assign acc_next  = ACC_W'(delay_base) + ACC_W'(im1) * ACC_W'(delay_step);
    assign rprod     = RP_W'(prod_reg) * RP_W'(RECIP_M);
    assign sum       = SUM_W'(acc_reg) + SUM_W'(scaled_reg);

    // Result of the final step, saturated to the delay width.
    always_comb
    begin
        if (ctl.op == OP_OOR)
        begin
            delay        = '0;
            out_of_range = 1'b1;
        end
        else
        begin
            delay        = (sum > SUM_W'(DELAY_MAX)) ? DELAY_MAX : DELAY_W'(sum);
            out_of_range = 1'b0;
        end
    end

    // Control state: entry counter, flags and divider step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg    <= '0;
            bad_reg  <= 1'b0;
            miss_reg <= 1'b0;
            k_reg    <= '0;
        end
        else if (start)
        begin
            i_reg   <= '0;
            bad_reg <= !tab_ok || (used == '0);
        end
        else if (fire)
        begin
            case (ctl.op)
                OP_SCAN:
                begin
                    if (stat.more)
                    begin
                        i_reg <= i_reg + IW'(1);
                    end
                    miss_reg <= above || (i_reg == '0);
                end
                OP_MUL:  k_reg <= K_INIT;
                OP_DIV:  k_reg <= k_reg - KW'(1);
                default: begin end
            endcase
        end
    end

    // Operand registers, one operation per step.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            goal_reg <= goal_distance;
            base_reg <= AW'(table_select) * AW'(ENTRIES);
        end
        else if (fire)
        begin
            case (ctl.op)
                OP_SCAN:
                begin
                    if (above)
                    begin
                        lower_reg <= rd_data;
                    end
                    else
                    begin
                        upper_reg <= rd_data;
                    end
                end
                OP_DIFF:
                begin
                    num_reg <= NUM_W'(goal_reg - lower_reg);
                    den_reg <= upper_reg - lower_reg;
                end
                OP_MUL:
                begin
                    num_reg <= num_mul;
                    quo_reg <= '0;
                end
                OP_DIV:
                begin
                    if (num_reg >= trial)
                    begin
                        num_reg        <= num_reg - trial;
                        quo_reg[k_reg] <= 1'b1;
                    end
                end
                OP_PROD:
                begin
                    prod_reg <= prod_next;
                    acc_reg  <= acc_next;
                end
                OP_RECIP: scaled_reg <= rprod[RECIP_SH +: SCALED_W];
                default:  begin end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/piecewise_linear_delay_lookup_core.sv =====
// Load: one per cycle when idle, written to the table store at its transfer; no result.
// Query: the result follows the scan of the entries and the interpolation steps below;
// an invalid table or entry count, or a goal outside, ends in the out-of-range step.
// One query at a time: the next transfer can be taken once its result is registered.
// Steps: check, two per entry via the registered read, test, 2 setup, 7 divide, 3 arithmetic.
// Backpressure holds the last step. Reset loads register defaults; tables stay undefined.
`default_nettype none

module piecewise_linear_delay_lookup_core import pwl_pkg::*; #(
    parameter int TABLES  = TABLES_DEF,
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Input stream.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // table_select[1:0], entry_index[5:2], entry_distance[37:6], goal_distance[69:38]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    // command[0]
    input  wire logic                   s_tuser,
    // Result stream.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // delay[20:0]
    output logic      [OUT_TDATA_W-1:0] m_tdata,
    // out_of_range[0]
    output logic                        m_tuser,
    // Configuration write port.
    input  wire logic                   cfg_write,
    input  wire logic [CIDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int AW = $clog2(TABLES * ENTRIES);

    logic [USED_W-1:0]  entries_used_reg;
    logic [CFG_W-1:0]   delay_base_reg;
    logic [CFG_W-1:0]   delay_step_reg;

    logic               out_valid_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               oor_reg;

    logic [TSEL_W-1:0]  table_select;
    logic [EIDX_W-1:0]  entry_index;
    logic [DIST_W-1:0]  entry_distance;
    logic [DIST_W-1:0]  goal_distance;

    logic               take;
    logic               start;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [DIST_W-1:0]  rd_data;

    ctl_t               ctl;
    stat_t              stat;
    logic               fire;
    logic               done;
    logic               busy;
    logic               out_free;
    logic [DELAY_W-1:0] dp_delay;
    logic               dp_oor;

    // Unpack the input payload.
    assign table_select   = s_tdata[TSEL_LSB +: TSEL_W];
    assign entry_index    = s_tdata[EIDX_LSB +: EIDX_W];
    assign entry_distance = s_tdata[EDIST_LSB +: DIST_W];
    assign goal_distance  = s_tdata[GOAL_LSB +: DIST_W];

    // Input handshake: loads complete at the transfer, queries start the sequencer.
    assign s_tready = !busy;
    assign take     = s_tvalid && s_tready;
    assign start    = take && s_tuser;
    assign wr_en    = take && !s_tuser
                      && (32'(table_select) < 32'(TABLES))
                      && (32'(entry_index) < 32'(ENTRIES));
    assign wr_addr  = AW'(table_select) * AW'(ENTRIES) + AW'(entry_index);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used_reg <= ENTRIES_USED_RST;
            delay_base_reg   <= DELAY_BASE_RST;
            delay_step_reg   <= DELAY_STEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ENTRIES_USED: entries_used_reg <= cfg_data[USED_W-1:0];
                REG_DELAY_BASE:   delay_base_reg   <= cfg_data;
                REG_DELAY_STEP:   delay_step_reg   <= cfg_data;
                default:          begin end
            endcase
        end
    end

    // Calibration distance store, all tables in one memory.
    pwl_ram #(
        .WIDTH (DIST_W),
        .DEPTH (TABLES * ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (entry_distance),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pwl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .stat     (stat),
        .out_free (out_free),
        .ctl      (ctl),
        .fire     (fire),
        .done     (done),
        .busy     (busy)
    );

    pwl_dpath #(
        .TABLES  (TABLES),
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .table_select  (table_select),
        .goal_distance (goal_distance),
        .entries_used  (entries_used_reg),
        .delay_base    (delay_base_reg),
        .delay_step    (delay_step_reg),
        .ctl           (ctl),
        .fire          (fire),
        .rd_data       (rd_data),
        .rd_addr       (rd_addr),
        .stat          (stat),
        .delay         (dp_delay),
        .out_of_range  (dp_oor)
    );

    // Output register: holds a result until its transfer.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            delay_reg <= dp_delay;
            oor_reg   <= dp_oor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(delay_reg);
    assign m_tuser  = oor_reg;

endmodule

`default_nettype wire

// ===== sv/pwl_chk.sv =====
`default_nettype none
`include "assert_macros.svh"

module pwl_chk import pwl_pkg::*; (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata,
    input wire logic                   m_tuser
);

    // A stalled result keeps its payload.
    `PWL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An out-of-range result carries a zero delay.
    `PWL_ASSERT_NOW(a_oor_zero, m_tvalid && m_tuser, m_tdata == {OUT_TDATA_W{1'b0}}, "out-of-range result with nonzero delay")

    // A load transfer never produces a result.
    `PWL_ASSERT_NEXT(a_load_silent, s_tvalid && s_tready && !s_tuser && !m_tvalid, !m_tvalid, "load produced a result")

    // A query occupies the block, so no transfer follows right after it.
    `PWL_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser, !s_tready, "input taken while a query is in work")

endmodule

bind piecewise_linear_delay_lookup_core pwl_chk u_chk (.*);

`default_nettype wire
